// ----- sv/mpts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mpts_pkg;

	localparam int POS_W        = 32;
	localparam int DATA_W       = 8;
	localparam int LEN_W        = 32;
	localparam int TYPE_W       = 3;
	localparam int TIME_W       = 33;
	localparam int PERIOD_W     = 19;
	localparam int COUNT_W      = 32;
	localparam int TREF_W       = 10;
	localparam int TERM_W       = 33;
	localparam int TERM_FULL_W  = COUNT_W + 3;
	localparam int LEN_EXT_W    = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int DTS_PROD_W   = COUNT_W + PERIOD_W;
	localparam int PTS_PROD_W   = TERM_W + PERIOD_W;
	localparam int ZRUN_W       = 2;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam logic [0:0] REG_FRAME_PERIOD = 1'b0;

	localparam logic [DATA_W-1:0] CODE_PICTURE = 8'h00;
	localparam logic [DATA_W-1:0] CODE_GROUP   = 8'hB8;
	localparam logic [DATA_W-1:0] BYTE_ZERO    = 8'h00;
	localparam logic [DATA_W-1:0] BYTE_ONE     = 8'h01;
	localparam logic [ZRUN_W-1:0] ZRUN_MAX     = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 19'd12012;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_CODE   = 4'b0010,
		PH_HDR_HI = 4'b0100,
		PH_HDR_LO = 4'b1000
	} phase_t;

	typedef enum logic {
		JOB_TIMES = 1'b0,
		JOB_EMIT  = 1'b1
	} job_kind_t;

	// arg_a: clamped pts term or picture length, arg_b: decode count
	typedef struct packed {
		job_kind_t          kind;
		logic [TERM_W-1:0]  arg_a;
		logic [COUNT_W-1:0] arg_b;
		logic [TYPE_W-1:0]  ptype;
	} job_t;

endpackage
`default_nettype wire

// ----- sv/mpts_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mpts_byte_if;
	import mpts_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/mpts_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mpts_result_if;
	import mpts_pkg::*;

	logic              valid;
	logic              ready;
	logic [LEN_W-1:0]  frame_length;
	logic [TYPE_W-1:0] picture_type;
	logic [TIME_W-1:0] decode_time;
	logic [TIME_W-1:0] present_time;

	modport source(output valid, output frame_length, output picture_type,
		output decode_time, output present_time, input ready);
	modport sink(input valid, input frame_length, input picture_type,
		input decode_time, input present_time, output ready);
endinterface
`default_nettype wire

// ----- sv/mpts_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mpts_front (
	input  logic             clk,
	input  logic             arst_n,
	mpts_byte_if.sink        stream,
	input  logic             queue_full,
	output logic             push,
	output mpts_pkg::job_t   push_job
);
	import mpts_pkg::*;

	phase_t              phase_q, phase_d;
	logic [ZRUN_W-1:0]   zrun_q, zrun_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [POS_W-1:0]    pstart_q, pstart_d;
	logic [DATA_W-1:0]   hdr_hi_q, hdr_hi_d;
	logic [COUNT_W-1:0]  dcount_q, dcount_d;
	logic [COUNT_W-1:0]  gcount_q, gcount_d;
	logic [TYPE_W-1:0]   ptype_q, ptype_d;

	logic                acc;
	logic [DATA_W-1:0]   b;
	logic [POS_W-1:0]    prefix;
	logic [POS_W-1:0]    diff;
	logic [LEN_EXT_W-1:0] diff_ext;
	logic [LEN_W-1:0]    len;
	logic [2*DATA_W-1:0] word;
	logic [TREF_W-1:0]   tref;
	logic [TERM_FULL_W-1:0] term_full;
	logic [TERM_W-1:0]   term;

	assign stream.ready = !queue_full;
	assign acc = stream.valid && !queue_full;
	assign b = stream.data_byte;

	// prefix started three bytes back
	assign prefix   = pos_q - POS_W'(3);
	assign diff     = prefix - pstart_q;
	assign diff_ext = LEN_EXT_W'(diff);
	assign len = (diff_ext > LEN_EXT_W'(32'hFFFF_FFFF)) ? '1 : diff_ext[LEN_W-1:0];

	assign word = {hdr_hi_q, b};
	assign tref = word[15:6];
	assign term_full = TERM_FULL_W'(tref) + TERM_FULL_W'(dcount_q) + TERM_FULL_W'(1)
		- TERM_FULL_W'(gcount_q);
	assign term = term_full[TERM_FULL_W-1] ? '0 : term_full[TERM_W-1:0];

	always_comb begin
		phase_d  = phase_q;
		zrun_d   = zrun_q;
		pos_d    = pos_q;
		pstart_d = pstart_q;
		hdr_hi_d = hdr_hi_q;
		dcount_d = dcount_q;
		gcount_d = gcount_q;
		ptype_d  = ptype_q;
		push     = 1'b0;
		push_job = '0;
		if (acc) begin
			pos_d = pos_q + POS_W'(1);
			case (phase_q)
				PH_HUNT: begin
					if (b == BYTE_ZERO) begin
						if (zrun_q < ZRUN_MAX) zrun_d = zrun_q + ZRUN_W'(1);
					end else if (b == BYTE_ONE && zrun_q >= ZRUN_MAX) begin
						zrun_d  = '0;
						phase_d = PH_CODE;
					end else begin
						zrun_d = '0;
					end
				end
				PH_CODE: begin
					zrun_d  = '0;
					phase_d = PH_HUNT;
					if (b == CODE_GROUP) begin
						gcount_d = '0;
					end else if (b == CODE_PICTURE) begin
						phase_d = PH_HDR_HI;
						if (dcount_q != '0) begin
							push           = 1'b1;
							push_job.kind  = JOB_EMIT;
							push_job.arg_a = TERM_W'(len);
							push_job.ptype = ptype_q;
							pstart_d       = prefix;
						end
					end
				end
				PH_HDR_HI: begin
					hdr_hi_d = b;
					phase_d  = PH_HDR_LO;
				end
				PH_HDR_LO: begin
					ptype_d        = word[5:3];
					push           = 1'b1;
					push_job.kind  = JOB_TIMES;
					push_job.arg_a = term;
					push_job.arg_b = dcount_q;
					dcount_d       = dcount_q + COUNT_W'(1);
					gcount_d       = gcount_q + COUNT_W'(1);
					phase_d        = PH_HUNT;
					// low header byte also starts a new zero run
					zrun_d = (b == BYTE_ZERO) ? ZRUN_W'(1) : '0;
				end
				default: begin
					phase_d = PH_HUNT;
					zrun_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			zrun_q   <= '0;
			pos_q    <= '0;
			pstart_q <= '0;
			hdr_hi_q <= '0;
			dcount_q <= '0;
			gcount_q <= '0;
			ptype_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			zrun_q   <= zrun_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
			hdr_hi_q <= hdr_hi_d;
			dcount_q <= dcount_d;
			gcount_q <= gcount_d;
			ptype_q  <= ptype_d;
		end
	end
endmodule
`default_nettype wire

// ----- sv/mpts_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mpts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mpts_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output mpts_pkg::job_t  head_job
);
	import mpts_pkg::*;

	job_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (!push && do_pop) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end
endmodule
`default_nettype wire

// ----- sv/mpts_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mpts_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mpts_pkg::PERIOD_W-1:0]   period,
	input  logic                            head_valid,
	input  mpts_pkg::job_t                  head_job,
	output logic                            pop,
	mpts_result_if.source                   result
);
	import mpts_pkg::*;

	logic                  valid_s1;
	job_t                  job_s1;
	logic                  adv;
	logic [DTS_PROD_W-1:0] dts_prod;
	logic [PTS_PROD_W-1:0] pts_prod;
	logic [TIME_W-1:0]     held_dts_q;
	logic [TIME_W-1:0]     held_pts_q;
	logic                  out_valid_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [TYPE_W-1:0]     out_type_q;
	logic [TIME_W-1:0]     out_dts_q;
	logic [TIME_W-1:0]     out_pts_q;

	// timing jobs never wait, emit jobs wait for a free output register
	assign adv = valid_s1 && (job_s1.kind == JOB_TIMES || !out_valid_q || result.ready);
	assign pop = head_valid && (!valid_s1 || adv);

	assign dts_prod = DTS_PROD_W'(job_s1.arg_b) * DTS_PROD_W'(period);
	assign pts_prod = PTS_PROD_W'(job_s1.arg_a) * PTS_PROD_W'(period);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_s1 <= head_job;
	end

	// period is q.2, drop the fraction and keep 33 bits
	always_ff @(posedge clk) begin
		if (adv && job_s1.kind == JOB_TIMES) begin
			held_dts_q <= dts_prod[TIME_W+1:2];
			held_pts_q <= pts_prod[TIME_W+1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && job_s1.kind == JOB_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && job_s1.kind == JOB_EMIT) begin
			out_len_q  <= job_s1.arg_a[LEN_W-1:0];
			out_type_q <= job_s1.ptype;
			out_dts_q  <= held_dts_q;
			out_pts_q  <= held_pts_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_length = out_len_q;
	assign result.picture_type = out_type_q;
	assign result.decode_time  = out_dts_q;
	assign result.present_time = out_pts_q;
endmodule
`default_nettype wire

// ----- sv/mpeg_video_picture_timestamper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// mpeg-1 video picture timestamper
// stream: one elementary-stream byte per request, valid/ready handshake
// result: one request per picture start code after the first, describing the
//   previous picture: byte length, coding type, dts and pts in 90 kHz ticks
// apb port: register 0 at address 0 is the picture period in q.2 ticks,
//   write it only while the block is idle; pready is tied high
// throughput: one byte per cycle while the job queue has room, set by the
//   byte scanner in the front end; the timestamp unit behind the four-entry
//   job queue takes one job a cycle unless an emit job waits for the output
//   register; when the result side stalls, jobs collect in the queue and
//   stream.ready drops only once all four entries are full
// reset: scanner hunts for a prefix, counts and position clear, period
//   returns to 12012 (29.97 Hz), queue and output empty
// the last picture of a stream is never reported
module mpeg_video_picture_timestamper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mpts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [mpts_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mpts_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	mpts_byte_if.sink                         stream,
	mpts_result_if.source                     result
);
	import mpts_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic                reg_sel;
	logic                q_full;
	logic                push;
	job_t                push_job;
	logic                pop;
	logic                head_valid;
	job_t                head_job;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_FRAME_PERIOD);
	assign prdata  = reg_sel ? APB_DATA_W'(period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	mpts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.queue_full (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	mpts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	mpts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.period     (period_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.result     (result)
	);
endmodule
`default_nettype wire

// ----- sim/mpeg_video_picture_timestamper_test.sv -----
`timescale 1ns / 1ps
module mpeg_video_picture_timestamper_test;
	import mpts_pkg::*;

	localparam int BYTES_PER_PHASE = 230;
	localparam int SETTLE_CYCLES   = 20;
	localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = APB_ADDR_W'(REG_FRAME_PERIOD) << 2;
	localparam logic [DATA_W-1:0] CODE_SEQ_HEADER = 8'hB3;

	typedef struct {
		logic [DATA_W-1:0] value;
		bit                hold;
	} stream_byte_t;

	typedef struct {
		logic [LEN_W-1:0]  length;
		logic [TYPE_W-1:0] ptype;
		logic [TIME_W-1:0] dts;
		logic [TIME_W-1:0] pts;
	} picture_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mpts_byte_if   stream_bus ();
	mpts_result_if result_bus ();

	mpeg_video_picture_timestamper u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.stream  (stream_bus),
		.result  (result_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	stream_byte_t    stream_bytes[$];
	picture_report_t picture_reports[$];
	int              mismatches = 0;
	int              phase_bytes;
	bit              byte_in_flight = 1'b0;
	int              stream_gap = 0;
	int              stream_quiet = 0;
	int              result_stall = 0;
	int              result_quiet = 0;

	// timestamp tracker state
	logic [PERIOD_W-1:0] frame_period = PERIOD_RESET;
	logic [ZRUN_W-1:0]   zeros_seen = '0;
	phase_t              parse_state = PH_HUNT;
	logic [POS_W-1:0]    stream_pos = '0;
	logic [POS_W-1:0]    last_picture_pos = '0;
	logic [DATA_W-1:0]   tref_high = '0;
	logic [COUNT_W-1:0]  pictures_decoded = '0;
	logic [COUNT_W-1:0]  pictures_in_group = '0;
	logic [TYPE_W-1:0]   prev_type = '0;
	logic [TIME_W-1:0]   prev_dts = '0;
	logic [TIME_W-1:0]   prev_pts = '0;

	task automatic report_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
	endtask

	task automatic hunt_prefix(input logic [DATA_W-1:0] b);
		if (b == BYTE_ZERO) begin
			if (zeros_seen < ZRUN_MAX)
				zeros_seen = zeros_seen + 1'b1;
		end else if (b == BYTE_ONE && zeros_seen >= ZRUN_MAX) begin
			zeros_seen = '0;
			parse_state = PH_CODE;
		end else begin
			zeros_seen = '0;
		end
	endtask

	task automatic track_stream_byte(input logic [DATA_W-1:0] b);
		logic [15:0]      word;
		logic [POS_W-1:0] prefix_pos;
		longint           term;
		logic [63:0]      product;
		picture_report_t  rep;
		case (parse_state)
			PH_HUNT: hunt_prefix(b);
			PH_CODE: begin
				zeros_seen = '0;
				parse_state = PH_HUNT;
				if (b == CODE_GROUP) begin
					pictures_in_group = '0;
				end else if (b == CODE_PICTURE) begin
					prefix_pos = stream_pos - 3;
					// no report until a first picture has been timed
					if (pictures_decoded != 0) begin
						rep.length = prefix_pos - last_picture_pos;
						rep.ptype = prev_type;
						rep.dts = prev_dts;
						rep.pts = prev_pts;
						picture_reports.push_back(rep);
						last_picture_pos = prefix_pos;
					end
					parse_state = PH_HDR_HI;
				end
			end
			PH_HDR_HI: begin
				tref_high = b;
				parse_state = PH_HDR_LO;
			end
			default: begin
				word = {tref_high, b};
				prev_type = word[5:3];
				product = 64'(pictures_decoded) * 64'(frame_period);
				prev_dts = product[TIME_W+1:2];
				term = longint'(word[15:6]) - longint'(pictures_in_group) + 1
					+ longint'(pictures_decoded);
				if (term < 0) begin
					prev_pts = '0;
				end else begin
					product = 64'(term) * 64'(frame_period);
					prev_pts = product[TIME_W+1:2];
				end
				pictures_decoded++;
				pictures_in_group++;
				parse_state = PH_HUNT;
				zeros_seen = '0;
				// second header byte is also plain stream data
				hunt_prefix(b);
			end
		endcase
		stream_pos++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// stream side: bytes change on the falling edge
	always @(negedge clk) begin : stream_drive
		stream_byte_t next;
		if (arst_n && !byte_in_flight) begin
			if (stream_gap > 0) begin
				stream_bus.valid <= 1'b0;
				stream_gap--;
			end else if (stream_bytes.size() != 0
				&& !(stream_bytes[0].hold && picture_reports.size() != 0)) begin
				next = stream_bytes.pop_front();
				stream_bus.valid <= 1'b1;
				stream_bus.data_byte <= next.value;
				byte_in_flight = 1'b1;
				if (stream_quiet > 0) begin
					stream_quiet--;
				end else begin
					stream_gap = pick_gap();
					if ($urandom_range(0, 99) == 0)
						stream_quiet = $urandom_range(30, 120);
				end
			end else begin
				stream_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && stream_bus.valid && stream_bus.ready) begin
			track_stream_byte(stream_bus.data_byte);
			byte_in_flight = 1'b0;
		end
	end

	always @(negedge clk) begin : result_drive
		if (arst_n) begin
			if (result_stall > 0) begin
				result_bus.ready <= 1'b0;
				result_stall--;
			end else begin
				result_bus.ready <= 1'b1;
				if (result_quiet > 0) begin
					result_quiet--;
				end else begin
					result_stall = pick_gap();
					if ($urandom_range(0, 99) == 0)
						result_quiet = $urandom_range(30, 120);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		picture_report_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (picture_reports.size() == 0) begin
				report_mismatch("result with nothing pending", '0, result_bus.frame_length);
			end else begin
				want = picture_reports.pop_front();
				if (result_bus.frame_length !== want.length)
					report_mismatch("frame_length", want.length, result_bus.frame_length);
				if (result_bus.picture_type !== want.ptype)
					report_mismatch("picture_type", want.ptype, result_bus.picture_type);
				if (result_bus.decode_time !== want.dts)
					report_mismatch("decode_time", want.dts, result_bus.decode_time);
				if (result_bus.present_time !== want.pts)
					report_mismatch("present_time", want.pts, result_bus.present_time);
			end
		end
	end

	task automatic push_byte(input logic [DATA_W-1:0] v, input bit hold = 1'b0);
		stream_bytes.push_back('{value: v, hold: hold});
		phase_bytes++;
	endtask

	task automatic push_prefix(input bit hold);
		int extra;
		extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
		push_byte(BYTE_ZERO, hold);
		push_byte(BYTE_ZERO);
		repeat (extra) push_byte(BYTE_ZERO);
		push_byte(BYTE_ONE);
	endtask

	task automatic push_payload(input int len);
		repeat (len) begin
			if ($urandom_range(0, 2) == 0)
				push_byte(BYTE_ZERO);
			else
				push_byte(DATA_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_directed();
		// first picture, every header bit set: reported at the next picture code
		push_byte(BYTE_ZERO); push_byte(BYTE_ZERO); push_byte(BYTE_ONE);
		push_byte(CODE_PICTURE); push_byte(8'hFF); push_byte(8'hFF);
		// group start behind a longer zero run
		push_byte(BYTE_ZERO); push_byte(BYTE_ZERO); push_byte(BYTE_ZERO);
		push_byte(BYTE_ONE); push_byte(CODE_GROUP);
		// code byte and first header byte of zero must not form a prefix
		push_byte(BYTE_ZERO); push_byte(BYTE_ZERO); push_byte(BYTE_ONE);
		push_byte(CODE_PICTURE); push_byte(BYTE_ZERO); push_byte(BYTE_ONE);
		// zero second header byte starts the next prefix
		push_byte(BYTE_ZERO); push_byte(BYTE_ZERO); push_byte(BYTE_ONE);
		push_byte(CODE_PICTURE); push_byte(BYTE_ZERO); push_byte(BYTE_ZERO);
		push_byte(BYTE_ZERO); push_byte(BYTE_ONE); push_byte(CODE_SEQ_HEADER);
	endtask

	task automatic add_random(input int budget);
		int                pick;
		int                n;
		logic [TREF_W-1:0] tref;
		logic [TYPE_W-1:0] ptype;
		logic [15:0]       word;
		logic [DATA_W-1:0] code;
		phase_bytes = 0;
		while (phase_bytes < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				push_prefix($urandom_range(0, 39) == 0);
				push_byte(CODE_PICTURE);
				tref = TREF_W'($urandom_range(0, 1023));
				if ($urandom_range(0, 9) < 8)
					ptype = TYPE_W'($urandom_range(1, 4));
				else
					ptype = TYPE_W'($urandom_range(0, 7));
				word = {tref, ptype, 3'($urandom_range(0, 7))};
				push_byte(word[15:8]);
				push_byte(word[7:0]);
				if ($urandom_range(0, 9) == 0)
					push_payload($urandom_range(13, 80));
				else
					push_payload($urandom_range(0, 12));
			end else if (pick < 73) begin
				push_prefix(1'b0);
				push_byte(CODE_GROUP);
				push_payload(4);
			end else if (pick < 80) begin
				push_prefix(1'b0);
				code = DATA_W'($urandom_range(1, 255));
				if (code == CODE_GROUP)
					code = CODE_SEQ_HEADER;
				push_byte(code);
				push_payload($urandom_range(0, 6));
			end else if (pick < 90) begin
				// broken prefix
				n = $urandom_range(1, 2);
				repeat (n) push_byte(BYTE_ZERO);
				if (n == 2)
					push_byte(DATA_W'($urandom_range(2, 255)));
				else
					push_byte(DATA_W'($urandom_range(1, 255)));
			end else begin
				repeat ($urandom_range(1, 8)) push_byte(DATA_W'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic settle();
		while (stream_bytes.size() != 0 || byte_in_flight || picture_reports.size() != 0)
			@(posedge clk);
		// header bytes still being timed produce no result
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit is_write, input logic [APB_DATA_W-1:0] wdata,
		output logic [APB_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= PERIOD_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_period(input logic [PERIOD_W-1:0] want);
		logic [APB_DATA_W-1:0] got;
		apb_access(1'b0, '0, got);
		if (got !== APB_DATA_W'(want))
			report_mismatch("frame_period_q2 read", want, got);
	endtask

	task automatic set_period(input logic [PERIOD_W-1:0] v);
		logic [APB_DATA_W-1:0] unused;
		apb_access(1'b1, APB_DATA_W'(v), unused);
		frame_period = v;
		check_period(v);
	endtask

	initial begin : stimulus
		logic [PERIOD_W-1:0] period_plan[6];
		period_plan = '{19'd4, 19'd360000, 19'd0, 19'd1, 19'h7FFFF, 19'd0};
		period_plan[5] = PERIOD_W'($urandom_range(4, 360000));
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stream_bus.valid = 1'b0;
		stream_bus.data_byte = '0;
		result_bus.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_period(PERIOD_RESET);
		phase_bytes = 0;
		add_directed();
		add_random(BYTES_PER_PHASE);
		settle();
		foreach (period_plan[i]) begin
			set_period(period_plan[i]);
			add_random(BYTES_PER_PHASE);
			settle();
		end
		if (mismatches == 0 && picture_reports.size() == 0)
			$display("mpeg_video_picture_timestamper regression: pass");
		else
			$display("mpeg_video_picture_timestamper regression: fail");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("mpeg_video_picture_timestamper regression: fail");
		$finish;
	end

endmodule
